/* hw/rtl/sync_word_frame_receiver_crc8_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sync-word frame receiver
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef SYNC_WORD_FRAME_RECEIVER_CRC8_DEFINES_SVH
`define SYNC_WORD_FRAME_RECEIVER_CRC8_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWFR_ASSERT_SAME(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("swfr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SWFR_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("swfr assertion failed");

`endif

/* hw/rtl/swfr_pkg.sv */
// ---------------------------------------------------------------------------
// swfr_pkg
// Types, constants and the CRC-8 step shared by the frame receiver modules.
// ---------------------------------------------------------------------------
package swfr_pkg;

	localparam int MAX_PAYLOAD = 1024;

	// Length register saturates at MAX_PAYLOAD + 1.
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 2);
	// Frame byte position reaches MAX_PAYLOAD + 25 at the last stop byte.
	localparam int POS_W = $clog2(MAX_PAYLOAD + 27);
	localparam int ACC_W = LEN_W + 8;

	localparam int IDX_W    = 10;
	localparam int FLEN_W   = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TDATA_W  = 40;

	// Frame byte positions, start pattern counted as bytes one to eight.
	localparam logic [POS_W-1:0] POS_WINDOW_FULL = POS_W'(8);
	localparam logic [POS_W-1:0] POS_VER_MAJOR   = POS_W'(9);
	localparam logic [POS_W-1:0] POS_VER_MINOR   = POS_W'(10);
	localparam logic [POS_W-1:0] POS_SENDER      = POS_W'(11);
	localparam logic [POS_W-1:0] POS_DEST        = POS_W'(12);
	localparam logic [POS_W-1:0] POS_LEN_LAST    = POS_W'(16);
	localparam logic [POS_W-1:0] POS_CRC_BASE    = POS_W'(17);
	localparam logic [POS_W-1:0] POS_STOP_BASE   = POS_W'(25);

	localparam logic [7:0] CRC8_POLY_REFL = 8'h8C;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_HIGH = 3'd0,
		REG_START_LOW  = 3'd1,
		REG_STOP_HIGH  = 3'd2,
		REG_STOP_LOW   = 3'd3,
		REG_VER_MAJOR  = 3'd4,
		REG_VER_MINOR  = 3'd5,
		REG_OWN_ADDR   = 3'd6
	} reg_index_t;

	localparam logic [31:0] RST_START_HIGH = 32'h314E3752;
	localparam logic [31:0] RST_START_LOW  = 32'h4F494E6D;
	localparam logic [31:0] RST_STOP_HIGH  = 32'h527B4439;
	localparam logic [31:0] RST_STOP_LOW   = 32'h38563839;
	localparam logic [7:0]  RST_VER_MAJOR  = 8'd48;
	localparam logic [7:0]  RST_VER_MINOR  = 8'd49;
	localparam logic [7:0]  RST_OWN_ADDR   = 8'd1;

	typedef enum logic [2:0] {
		ST_GOOD         = 3'd0,
		ST_BAD_VERSION  = 3'd1,
		ST_WRONG_ADDR   = 3'd2,
		ST_TOO_LONG     = 3'd3,
		ST_CRC_MISMATCH = 3'd4,
		ST_BAD_STOP     = 3'd5
	} status_t;

	typedef struct packed {
		logic [63:0] start_pattern;
		logic [63:0] stop_pattern;
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
		logic [7:0]  own_address;
	} cfg_t;

	typedef struct packed {
		logic              payload_valid;
		logic [7:0]        payload_byte;
		logic [IDX_W-1:0]  payload_index;
		logic              frame_end;
		status_t           frame_status;
		logic [FLEN_W-1:0] frame_length;
		logic [7:0]        sender_address;
	} result_t;

	// One byte of reflected CRC-8 (Maxim), eight shift steps.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC8_POLY_REFL) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hw/rtl/swfr_cfg_regs.sv */
// ---------------------------------------------------------------------------
// swfr_cfg_regs
// Configuration register file: patterns, expected version and own address.
// ---------------------------------------------------------------------------
module swfr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [swfr_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [swfr_pkg::CFG_DATA_W-1:0] wr_data,
	output swfr_pkg::cfg_t                 cfg
);
	import swfr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_pattern <= {RST_START_HIGH, RST_START_LOW};
			cfg_q.stop_pattern  <= {RST_STOP_HIGH, RST_STOP_LOW};
			cfg_q.version_major <= RST_VER_MAJOR;
			cfg_q.version_minor <= RST_VER_MINOR;
			cfg_q.own_address   <= RST_OWN_ADDR;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START_HIGH: cfg_q.start_pattern[63:32] <= wr_data;
				REG_START_LOW:  cfg_q.start_pattern[31:0]  <= wr_data;
				REG_STOP_HIGH:  cfg_q.stop_pattern[63:32]  <= wr_data;
				REG_STOP_LOW:   cfg_q.stop_pattern[31:0]   <= wr_data;
				REG_VER_MAJOR:  cfg_q.version_major <= wr_data[7:0];
				REG_VER_MINOR:  cfg_q.version_minor <= wr_data[7:0];
				REG_OWN_ADDR:   cfg_q.own_address   <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/swfr_deframer.sv */
// ---------------------------------------------------------------------------
// swfr_deframer
// Frame state and the per-byte decision logic: hunt, header checks, length,
// cut-through payload with CRC-8, CRC byte and stop pattern.
// ---------------------------------------------------------------------------
module swfr_deframer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        rx_byte,
	input  swfr_pkg::cfg_t    cfg,
	output swfr_pkg::result_t res
);
	import swfr_pkg::*;

	logic [63:0]      window_q, window_n, window_sh;
	logic [POS_W-1:0] pos_q, pos_n, pos_inc;
	logic             locked_q, locked_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [7:0]       crc_q, crc_n, crc_rx_q, crc_rx_n;
	logic [7:0]       sender_q, sender_n, ver_q, ver_n;
	logic [ACC_W-1:0] acc;
	logic [LEN_W-1:0] acc_sat;
	logic [POS_W-1:0] pay_last, crc_pos, stop_pos, pay_off;

	always_comb begin
		window_sh = {window_q[55:0], rx_byte};
		pos_inc   = pos_q + POS_W'(1);
		acc       = {len_q, rx_byte};
		acc_sat   = (acc > ACC_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD + 1) : acc[LEN_W-1:0];
		pay_last  = POS_LEN_LAST + POS_W'(len_q);
		crc_pos   = POS_CRC_BASE + POS_W'(len_q);
		stop_pos  = POS_STOP_BASE + POS_W'(len_q);
		pay_off   = pos_inc - POS_CRC_BASE;

		window_n = window_sh;
		pos_n    = pos_q;
		locked_n = locked_q;
		len_n    = len_q;
		crc_n    = crc_q;
		crc_rx_n = crc_rx_q;
		sender_n = sender_q;
		ver_n    = ver_q;
		res      = '0;

		if (!locked_q) begin
			if (pos_q < POS_WINDOW_FULL) pos_n = pos_inc;
			if ((pos_q >= POS_WINDOW_FULL - POS_W'(1)) && (window_sh == cfg.start_pattern)) begin
				locked_n = 1'b1;
			end
		end else begin
			pos_n = pos_inc;
			priority if (pos_inc == POS_VER_MAJOR) begin
				ver_n = rx_byte;
			end else if (pos_inc == POS_VER_MINOR) begin
				if (ver_q != cfg.version_major || rx_byte != cfg.version_minor) begin
					res.frame_end    = 1'b1;
					res.frame_status = ST_BAD_VERSION;
				end
			end else if (pos_inc == POS_SENDER) begin
				sender_n = rx_byte;
			end else if (pos_inc == POS_DEST) begin
				if (rx_byte != cfg.own_address) begin
					res.frame_end      = 1'b1;
					res.frame_status   = ST_WRONG_ADDR;
					res.sender_address = sender_q;
				end
			end else if (pos_inc <= POS_LEN_LAST) begin
				len_n = acc_sat;
				if (pos_inc == POS_LEN_LAST && acc > ACC_W'(MAX_PAYLOAD)) begin
					res.frame_end      = 1'b1;
					res.frame_status   = ST_TOO_LONG;
					res.sender_address = sender_q;
				end
			end else if (pos_inc <= pay_last) begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = pay_off[IDX_W-1:0];
				crc_n = crc8_step(crc_q, rx_byte);
			end else if (pos_inc == crc_pos) begin
				crc_rx_n = rx_byte;
			end else if (pos_inc >= stop_pos) begin
				res.frame_end      = 1'b1;
				res.frame_length   = FLEN_W'(len_q);
				res.sender_address = sender_q;
				if (window_sh != cfg.stop_pattern) res.frame_status = ST_BAD_STOP;
				else if (crc_q != crc_rx_q)         res.frame_status = ST_CRC_MISMATCH;
				else                                res.frame_status = ST_GOOD;
			end else begin
				// Between the CRC byte and the last stop byte: only the window and position move.
			end
			if (res.frame_end) begin
				window_n = '0;
				pos_n    = '0;
				locked_n = 1'b0;
				len_n    = '0;
				crc_n    = '0;
				crc_rx_n = '0;
				sender_n = '0;
				ver_n    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q    <= '0;
			locked_q <= 1'b0;
			len_q    <= '0;
			crc_q    <= '0;
			crc_rx_q <= '0;
			sender_q <= '0;
			ver_q    <= '0;
		end else if (advance) begin
			window_q <= window_n;
			pos_q    <= pos_n;
			locked_q <= locked_n;
			len_q    <= len_n;
			crc_q    <= crc_n;
			crc_rx_q <= crc_rx_n;
			sender_q <= sender_n;
			ver_q    <= ver_n;
		end
	end

endmodule

/* hw/rtl/swfr_out_stage.sv */
// ---------------------------------------------------------------------------
// swfr_out_stage
// Result register driving the master-side stream channel.
// ---------------------------------------------------------------------------
module swfr_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  swfr_pkg::result_t            res,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [swfr_pkg::TDATA_W-1:0] m_tdata,
	output logic                         m_tuser,
	output logic                         m_tlast
);
	import swfr_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.payload_valid;
	assign m_tlast  = res_s2.frame_end;
	assign m_tdata  = {res_s2.sender_address, res_s2.frame_length, res_s2.frame_status,
		res_s2.payload_index, res_s2.payload_byte};

endmodule

/* hw/rtl/sync_word_frame_receiver_crc8.sv */
// ---------------------------------------------------------------------------
// sync_word_frame_receiver_crc8
// Sync-word deframer with header checks, cut-through payload and CRC-8.
// ---------------------------------------------------------------------------
// The receiver takes one byte of a serial stream per word and returns exactly
// one result word for every byte taken, through the input register and the
// result register. It sustains one byte per clock unless the output stalls:
// each byte needs only one 64-bit window compare, one header or length step
// and one CRC-8 byte step, done combinationally between the two registers.
// While hunting it slides an eight-byte window over the stream and
// locks when the window matches the start pattern (never before eight bytes
// have been seen since reset or the last frame end). It then checks the two
// version bytes, records the sender byte, checks the destination byte against
// own_address, reads a big-endian 32-bit payload length, streams the payload
// out with its index (tuser high), takes the CRC byte and finally checks the
// eight-byte stop pattern. Every termination, good or aborted, is a word with
// tlast high carrying the status; the block then hunts again with its frame
// state cleared. Bad stop wins over a CRC mismatch. Lengths above 1024 abort
// with status "too long". Configuration may only be written while the block
// is idle; the configuration channel is always ready.
// ---------------------------------------------------------------------------
module sync_word_frame_receiver_crc8 (
	input  logic                            clk,
	input  logic                            arst_n,
	// Slave side: tdata[7:0] rx_byte
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,
	// Master side: tdata[7:0] payload_byte, [17:8] payload_index,
	// [20:18] frame_status, [31:21] frame_length, [39:32] sender_address
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [swfr_pkg::TDATA_W-1:0]    m_tdata,
	// tuser[0] payload_valid
	output logic                            m_tuser,
	// tlast is frame_end
	output logic                            m_tlast,
	// Configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swfr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swfr_pkg::*;
	`include "sync_word_frame_receiver_crc8_defines.svh"

	cfg_t    cfg;
	result_t res;
	logic    valid_s1;
	logic [7:0] byte_s1;
	logic    advance;

	assign cfg_ready = 1'b1;

	swfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The byte in the input register moves on whenever the result register
	// is empty or is being emptied in this cycle; the input register can then
	// take the next word in the same cycle.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	swfr_deframer u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	swfr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// A payload word never also ends a frame.
	`SWFR_ASSERT_SAME(a_payload_not_end, clk, arst_n, m_tvalid && m_tuser, !m_tlast)
	// Status and length are zero on any word that does not end a frame.
	`SWFR_ASSERT_SAME(a_status_only_at_end, clk, arst_n, m_tvalid && !m_tlast,
		m_tdata[31:18] == 14'd0)
	// A held byte with a stalled, full result register blocks the input.
	`SWFR_ASSERT_SAME(a_full_blocks_input, clk, arst_n, valid_s1 && m_tvalid && !m_tready,
		!s_tready)
	// A byte moved on always shows up as a result word in the next cycle.
	`SWFR_ASSERT_NEXT(a_advance_gives_result, clk, arst_n, advance, m_tvalid)

endmodule
